[rtl/core/stq_pkg.sv]
// ---------------------------------------------------------------------------
// stq_pkg
// Types and constants shared by the sorted timer queue cells and top level.
// ---------------------------------------------------------------------------
package stq_pkg;

    localparam int ID_BITS       = 4;
    localparam int ID_COUNT      = 1 << ID_BITS;
    localparam int IN_TIME_BITS  = 32;
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_TIME_BITS = 32;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_ADJUST = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_TICK
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [ID_BITS-1:0] id;
    } cell_cmd_t;

endpackage

[rtl/core/sorted_timer_queue_unit.sv]
// ---------------------------------------------------------------------------
// sorted_timer_queue_unit
// Timer list kept sorted by expiry in a shifting row of cells.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    kind, timer_id, expire_time, current_time
//  m_       out        m_valid / m_ready    expired_id, last_expired
//
//  add of a new id: accept, insert; adjust or add of a present id:
//  accept, remove, insert; delete of a present id: accept, remove;
//  adjust or delete of an absent id, or a new id on a full list: accept only.
//  tick: accept, then pop while the front cell is due; the front cell is popped once per
//  cycle into the output register, and a stall on m_ready holds the pop.
//  reset clears every cell valid bit, the presence mask and the sequencer.
// ---------------------------------------------------------------------------
module sorted_timer_queue_unit #(
    parameter int CAPACITY  = stq_pkg::DEF_CAPACITY,
    parameter int TIME_BITS = stq_pkg::DEF_TIME_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_kind,
    input  logic [stq_pkg::ID_BITS-1:0]     s_timer_id,
    input  logic [stq_pkg::IN_TIME_BITS-1:0] s_expire_time,
    input  logic [stq_pkg::IN_TIME_BITS-1:0] s_current_time,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [stq_pkg::ID_BITS-1:0]     m_expired_id,
    output logic                            m_last_expired
);
    import stq_pkg::*;

    state_t               state_reg, state_next;
    logic [ID_BITS-1:0]   op_id_reg, op_id_next;
    logic [TIME_BITS-1:0] op_time_reg, op_time_next;
    logic                 reinsert_reg, reinsert_next;
    logic [ID_COUNT-1:0]  present_mask_reg, present_mask_next;

    logic                 m_valid_reg, m_valid_next;
    logic [ID_BITS-1:0]   m_id_reg, m_id_next;
    logic                 m_last_reg, m_last_next;

    cell_cmd_t            cmd;

    logic                 cell_valid [CAPACITY];
    logic [ID_BITS-1:0]   cell_id    [CAPACITY];
    logic [TIME_BITS-1:0] cell_time  [CAPACITY];
    logic                 ins_chain  [CAPACITY+1];
    logic                 match_chain[CAPACITY+1];

    logic                 accept;
    logic                 present;
    logic                 full;
    logic                 front_due;
    logic                 second_due;
    logic                 pop_fire;

    assign ins_chain[0]   = 1'b0;
    assign match_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                 l_valid, r_valid;
            logic [ID_BITS-1:0]   l_id, r_id;
            logic [TIME_BITS-1:0] l_time, r_time;

            if (g == 0) begin : g_front
                assign l_valid = 1'b0;
                assign l_id    = '0;
                assign l_time  = '0;
            end else begin : g_mid_l
                assign l_valid = cell_valid[g-1];
                assign l_id    = cell_id[g-1];
                assign l_time  = cell_time[g-1];
            end

            if (g == CAPACITY - 1) begin : g_back
                assign r_valid = 1'b0;
                assign r_id    = '0;
                assign r_time  = '0;
            end else begin : g_mid_r
                assign r_valid = cell_valid[g+1];
                assign r_id    = cell_id[g+1];
                assign r_time  = cell_time[g+1];
            end

            stq_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .cmd_time   (op_time_reg),
                .left_valid (l_valid),
                .left_id    (l_id),
                .left_time  (l_time),
                .ins_in     (ins_chain[g]),
                .right_valid(r_valid),
                .right_id   (r_id),
                .right_time (r_time),
                .match_in   (match_chain[g]),
                .valid      (cell_valid[g]),
                .id         (cell_id[g]),
                .time_val   (cell_time[g]),
                .ins_out    (ins_chain[g+1]),
                .match_out  (match_chain[g+1])
            );
        end
    endgenerate

    assign accept     = s_valid && s_ready;
    assign present    = present_mask_reg[s_timer_id];
    assign full       = cell_valid[CAPACITY-1];
    // during a tick op_time_reg holds the current time
    assign front_due  = cell_valid[0] && (cell_time[0] <= op_time_reg);
    assign second_due = cell_valid[1] && (cell_time[1] <= op_time_reg);
    assign pop_fire   = (state_reg == ST_TICK) && front_due && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next    = state_reg;
        op_id_next    = op_id_reg;
        op_time_next  = op_time_reg;
        reinsert_next = reinsert_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_id_next    = s_timer_id;
                    op_time_next  = TIME_BITS'(s_expire_time);
                    reinsert_next = 1'b1;
                    case (kind_t'(s_kind))
                        KIND_ADD: begin
                            if (present) begin
                                state_next = ST_REMOVE;
                            end else if (!full) begin
                                state_next = ST_INSERT;
                            end
                        end
                        KIND_ADJUST: begin
                            if (present) begin
                                state_next = ST_REMOVE;
                            end
                        end
                        KIND_DELETE: begin
                            reinsert_next = 1'b0;
                            if (present) begin
                                state_next = ST_REMOVE;
                            end
                        end
                        KIND_TICK: begin
                            op_time_next = TIME_BITS'(s_current_time);
                            state_next   = ST_TICK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REMOVE: begin
                state_next = reinsert_reg ? ST_INSERT : ST_IDLE;
            end
            ST_INSERT: begin
                state_next = ST_IDLE;
            end
            ST_TICK: begin
                if (!front_due) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs, cell command, presence mask and result register
    always_comb begin
        s_ready           = (state_reg == ST_IDLE);
        cmd.op            = CELL_HOLD;
        cmd.id            = op_id_reg;
        present_mask_next = present_mask_reg;
        m_valid_next      = m_valid_reg;
        m_id_next         = m_id_reg;
        m_last_next       = m_last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_REMOVE: begin
                cmd.op                       = CELL_REMOVE;
                present_mask_next[op_id_reg] = 1'b0;
            end
            ST_INSERT: begin
                cmd.op                       = CELL_INSERT;
                present_mask_next[op_id_reg] = 1'b1;
            end
            ST_TICK: begin
                if (pop_fire) begin
                    cmd.op                        = CELL_POP;
                    present_mask_next[cell_id[0]] = 1'b0;
                    m_valid_next                  = 1'b1;
                    m_id_next                     = cell_id[0];
                    m_last_next                   = !second_due;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            present_mask_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            present_mask_reg <= present_mask_next;
            m_valid_reg      <= m_valid_next;
        end
        op_id_reg    <= op_id_next;
        op_time_reg  <= op_time_next;
        reinsert_reg <= reinsert_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_expired_id   = m_id_reg;
    assign m_last_expired = m_last_reg;

endmodule

[rtl/core/stq_cell.sv]
// ---------------------------------------------------------------------------
// stq_cell
// One slot of the sorted queue: holds a timer and shifts with its neighbours.
// ---------------------------------------------------------------------------
module stq_cell #(
    parameter int TIME_BITS = stq_pkg::DEF_TIME_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  stq_pkg::cell_cmd_t         cmd,
    input  logic [TIME_BITS-1:0]       cmd_time,
    // neighbour towards the front
    input  logic                       left_valid,
    input  logic [stq_pkg::ID_BITS-1:0] left_id,
    input  logic [TIME_BITS-1:0]       left_time,
    input  logic                       ins_in,
    // neighbour towards the back
    input  logic                       right_valid,
    input  logic [stq_pkg::ID_BITS-1:0] right_id,
    input  logic [TIME_BITS-1:0]       right_time,
    input  logic                       match_in,
    // own contents and chain outputs
    output logic                       valid,
    output logic [stq_pkg::ID_BITS-1:0] id,
    output logic [TIME_BITS-1:0]       time_val,
    output logic                       ins_out,
    output logic                       match_out
);
    import stq_pkg::*;

    logic                 valid_reg, valid_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0] time_reg, time_next;

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        time_next  = time_reg;
        // match ripples from the front: every slot at or behind the hit shifts
        match_out  = match_in | (valid_reg && (id_reg == cmd.id));
        // strict compare so an equal time lands behind existing entries
        ins_out    = !valid_reg || (cmd_time < time_reg);
        case (cmd.op)
            CELL_REMOVE: begin
                if (match_out) begin
                    valid_next = right_valid;
                    id_next    = right_id;
                    time_next  = right_time;
                end
            end
            CELL_INSERT: begin
                if (ins_out) begin
                    if (ins_in) begin
                        valid_next = left_valid;
                        id_next    = left_id;
                        time_next  = left_time;
                    end else begin
                        valid_next = 1'b1;
                        id_next    = cmd.id;
                        time_next  = cmd_time;
                    end
                end
            end
            CELL_POP: begin
                valid_next = right_valid;
                id_next    = right_id;
                time_next  = right_time;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        id_reg   <= id_next;
        time_reg <= time_next;
    end

    assign valid    = valid_reg;
    assign id       = id_reg;
    assign time_val = time_reg;

endmodule
